>>> sv/asdl_pkg.sv
// shared types and constants for the acceleration step detector with lockout
`default_nettype none
package asdl_pkg;

	localparam int WINDOW      = 100;
	localparam int SAMPLE_W    = 16;
	localparam int TOTAL_W     = SAMPLE_W + $clog2(WINDOW);
	localparam int LHS_W       = TOTAL_W + 1;
	localparam int THR_W       = 15;
	localparam int TICKS_W     = 16;
	localparam int OUT_TOTAL_W = 23;
	localparam int OUT_DATA_W  = 32;
	localparam int OUT_PAD_W   = OUT_DATA_W - 2 - OUT_TOTAL_W;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(154);
	localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(500);

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_TICK   = 1'b1
	} opcode_t;

	typedef enum logic {
		REG_THRESHOLD = 1'b0,
		REG_LOCKOUT   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0]   threshold;
		logic [TICKS_W-1:0] ticks;
	} cfg_t;

endpackage
`default_nettype wire

>>> sv/asdl_cell.sv
// one window cell: holds a sample and hands it to the next cell on a shift
`default_nettype none
module asdl_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          shift_en,
	input  wire logic [asdl_pkg::SAMPLE_W-1:0] d,
	output logic      [asdl_pkg::SAMPLE_W-1:0] q
);

	logic [asdl_pkg::SAMPLE_W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift_en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule
`default_nettype wire

>>> sv/asdl_regs.sv
// apb configuration registers: step threshold and lockout tick count
`default_nettype none
module asdl_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [asdl_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [asdl_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [asdl_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	output asdl_pkg::cfg_t                       cfg
);

	logic [asdl_pkg::THR_W-1:0]   threshold_q;
	logic [asdl_pkg::TICKS_W-1:0] ticks_q;
	asdl_pkg::reg_idx_t           idx;
	logic                         wr_en;

	assign idx    = asdl_pkg::reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= asdl_pkg::THR_RESET;
			ticks_q     <= asdl_pkg::TICKS_RESET;
		end else if (wr_en) begin
			case (idx)
				asdl_pkg::REG_THRESHOLD: threshold_q <= pwdata[asdl_pkg::THR_W-1:0];
				asdl_pkg::REG_LOCKOUT:   ticks_q     <= pwdata[asdl_pkg::TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			asdl_pkg::REG_THRESHOLD: prdata = asdl_pkg::APB_DATA_W'(threshold_q);
			asdl_pkg::REG_LOCKOUT:   prdata = asdl_pkg::APB_DATA_W'(ticks_q);
			default:                 prdata = '0;
		endcase
	end

	assign cfg.threshold = threshold_q;
	assign cfg.ticks     = ticks_q;

endmodule
`default_nettype wire

>>> sv/accel_step_detector_lockout.sv
// top level: window cell chain, running total, step decision and tick lockout
// path: a result reaches m_tvalid through two stage registers, s1 then s2, after its input
// one item per cycle unless m_tready stalls s2; window: a chain of cells shifted once per sample
// stages: s1 registers the sample and the updated running total, s2 holds the result
// reset: arst_n clears every window cell, the total and the lockout at once; no sweep
// reset also loads the default threshold and lockout tick count
`default_nettype none
module accel_step_detector_lockout (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// accel_z [15:0]
	input  wire logic [15:0]                     s_tdata,
	// opcode [0]
	input  wire logic [0:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// step [0], lockout_active [1], window_total [24:2], zero [31:25]
	output logic [asdl_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [asdl_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [asdl_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [asdl_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready
);

	localparam int SW = asdl_pkg::SAMPLE_W;
	localparam int TW = asdl_pkg::TOTAL_W;
	localparam int LW = asdl_pkg::LHS_W;

	asdl_pkg::cfg_t cfg;

	asdl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake between stages
	logic v_s1, v_s2, ready2, adv2, accept_in, shift_en;
	assign ready2    = !v_s2 || m_tready;
	assign adv2      = v_s1 && ready2;
	assign s_tready  = !v_s1 || ready2;
	assign accept_in = s_tvalid && s_tready;
	assign shift_en  = accept_in && (asdl_pkg::opcode_t'(s_tuser[0]) == asdl_pkg::OP_SAMPLE);

	// window chain: taps[0] is the incoming sample, the last tap the evicted one
	logic [SW-1:0] taps [asdl_pkg::WINDOW+1];
	assign taps[0] = s_tdata[SW-1:0];

	for (genvar i = 0; i < asdl_pkg::WINDOW; i++) begin : g_cell
		asdl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.d        (taps[i]),
			.q        (taps[i+1])
		);
	end

	logic [TW-1:0] total_q, total_d, new_ext, old_ext;
	assign new_ext = {{(TW-SW){taps[0][SW-1]}}, taps[0]};
	assign old_ext = {{(TW-SW){taps[asdl_pkg::WINDOW][SW-1]}}, taps[asdl_pkg::WINDOW]};
	assign total_d = total_q + new_ext - old_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (shift_en) begin
			total_q <= total_d;
		end
	end

	// stage 1 payload
	asdl_pkg::opcode_t op_s1;
	logic [SW-1:0]     sample_s1;
	logic [TW-1:0]     total_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			op_s1     <= asdl_pkg::opcode_t'(s_tuser[0]);
			sample_s1 <= s_tdata[SW-1:0];
			total_s1  <= shift_en ? total_d : total_q;
		end
	end

	// step decision: window*sample -/+ total against window*threshold
	logic [LW-1:0] prod, total_ext, lhs, limit;
	logic          step_hit;
	assign prod      = {{(LW-SW){sample_s1[SW-1]}}, sample_s1} * LW'(asdl_pkg::WINDOW);
	assign total_ext = {total_s1[TW-1], total_s1};
	assign lhs       = total_s1[TW-1] ? prod + total_ext : prod - total_ext;
	assign limit     = LW'(cfg.threshold) * LW'(asdl_pkg::WINDOW);

	logic                           lock_q, lock_d;
	logic [asdl_pkg::TICKS_W-1:0]   remain_q, remain_d;

	assign step_hit = (op_s1 == asdl_pkg::OP_SAMPLE) && !lock_q && !sample_s1[SW-1]
		&& ($signed(lhs) > $signed(limit));

	always_comb begin
		lock_d   = lock_q;
		remain_d = remain_q;
		if (op_s1 == asdl_pkg::OP_SAMPLE) begin
			if (step_hit) begin
				lock_d   = 1'b1;
				remain_d = cfg.ticks;
			end
		end else if (lock_q) begin
			if (remain_q <= asdl_pkg::TICKS_W'(1)) begin
				lock_d   = 1'b0;
				remain_d = '0;
			end else begin
				remain_d = remain_q - asdl_pkg::TICKS_W'(1);
			end
		end
	end

	logic                             step_s2, lock_s2;
	logic [asdl_pkg::OUT_TOTAL_W-1:0] total_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			lock_q   <= 1'b0;
			remain_q <= '0;
		end else begin
			if (ready2) begin
				v_s2 <= v_s1;
			end
			if (adv2) begin
				lock_q   <= lock_d;
				remain_q <= remain_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			step_s2  <= step_hit;
			lock_s2  <= lock_d;
			total_s2 <= asdl_pkg::OUT_TOTAL_W'($signed(total_s1));
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {{asdl_pkg::OUT_PAD_W{1'b0}}, total_s2, lock_s2, step_s2};

endmodule
`default_nettype wire

>>> sv/asdl_checker.sv
// port-level checker for the step detector, bound to the top level
`default_nettype none
module asdl_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [asdl_pkg::OUT_DATA_W-1:0] m_tdata
);

	// no result is shown while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// a stalled result holds its data
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// a flagged step always leaves the lockout running
	a_step_locks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("step without lockout");

	// the input side never stalls while the output side drains
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

endmodule

bind accel_step_detector_lockout asdl_checker u_asdl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

>>> verif/accel_step_detector_lockout_tb.sv
// self-checking testbench for the acceleration step detector with tick lockout
`default_nettype none
module accel_step_detector_lockout_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 4000;

	typedef struct {
		bit                               step;
		bit                               lock;
		logic [asdl_pkg::OUT_TOTAL_W-1:0] total;
	} detect_result_t;

	typedef enum logic {
		ROW_ITEM = 1'b0,
		ROW_CFG  = 1'b1
	} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		asdl_pkg::opcode_t  op;
		logic [15:0]        accel;
		int                 reps;
		asdl_pkg::reg_idx_t idx;
		logic [31:0]        value;
		bit                 typed;
		detect_result_t     want;
	} stim_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [asdl_pkg::OUT_DATA_W-1:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [asdl_pkg::APB_ADDR_W-1:0] paddr  = '0;
	logic [asdl_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [asdl_pkg::APB_DATA_W-1:0] prdata;
	logic        pready;

	accel_step_detector_lockout dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic signed [asdl_pkg::SAMPLE_W-1:0] win_buf [asdl_pkg::WINDOW];
	int                                   win_pos;
	longint                               win_sum;
	bit                                   hold_off;
	int unsigned                          hold_left;
	logic [asdl_pkg::THR_W-1:0]           cur_thr;
	logic [asdl_pkg::TICKS_W-1:0]         cur_ticks;

	detect_result_t pending_results [$];
	stim_row_t      stim_rows [$];

	int send_idle = 0;
	int recv_idle = 0;
	int errors = 0;
	int items_sent = 0;
	int ticks_sent = 0;
	int steps_seen = 0;
	int cfg_writes = 0;
	int stall_cnt = 0;

	function automatic detect_result_t detector_predict(asdl_pkg::opcode_t op,
			logic signed [15:0] z);
		detect_result_t r;
		longint lhs;
		longint limit;
		r.step = 1'b0;
		if (op == asdl_pkg::OP_SAMPLE) begin
			limit = longint'(asdl_pkg::WINDOW) * longint'(cur_thr);
			win_sum += longint'(z) - longint'(win_buf[win_pos]);
			win_buf[win_pos] = z;
			win_pos = (win_pos + 1) % asdl_pkg::WINDOW;
			// a negative total flips the sign of the mean term
			if (win_sum >= 0)
				lhs = longint'(asdl_pkg::WINDOW) * longint'(z) - win_sum;
			else
				lhs = longint'(asdl_pkg::WINDOW) * longint'(z) + win_sum;
			if (!hold_off && z >= 0 && lhs > limit) begin
				r.step    = 1'b1;
				hold_off  = 1'b1;
				hold_left = cur_ticks;
			end
		end else if (hold_off) begin
			if (hold_left <= 1) begin
				hold_left = 0;
				hold_off  = 1'b0;
			end else begin
				hold_left--;
			end
		end
		r.lock  = hold_off;
		r.total = win_sum[asdl_pkg::OUT_TOTAL_W-1:0];
		return r;
	endfunction

	function automatic stim_row_t item_row(asdl_pkg::opcode_t op, logic [15:0] z, int reps);
		stim_row_t r;
		r = '{kind: ROW_ITEM, op: op, accel: z, reps: reps, idx: asdl_pkg::REG_THRESHOLD,
			value: '0, typed: 1'b0, want: '{1'b0, 1'b0, '0}};
		return r;
	endfunction

	function automatic stim_row_t typed_row(asdl_pkg::opcode_t op, logic [15:0] z, bit step,
			bit lock, int total);
		stim_row_t r;
		r = item_row(op, z, 1);
		r.typed = 1'b1;
		r.want  = '{step, lock, asdl_pkg::OUT_TOTAL_W'(total)};
		return r;
	endfunction

	function automatic stim_row_t cfg_row(asdl_pkg::reg_idx_t idx, logic [31:0] value);
		stim_row_t r;
		r = item_row(asdl_pkg::OP_TICK, '0, 0);
		r.kind  = ROW_CFG;
		r.idx   = idx;
		r.value = value;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// one input transaction, with a random gap in front of it
	task automatic send_item(asdl_pkg::opcode_t op, logic [15:0] z, bit typed,
			detect_result_t want);
		detect_result_t got;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= z;
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		got = detector_predict(op, z);
		pending_results.push_back(typed ? want : got);
		items_sent++;
		if (op == asdl_pkg::OP_TICK)
			ticks_sent++;
	endtask

	// registers change only with nothing in flight
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apb_write_reg(asdl_pkg::reg_idx_t idx, logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] stored;
		stored = (idx == asdl_pkg::REG_THRESHOLD) ? (value & 32'h7FFF) : (value & 32'hFFFF);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == asdl_pkg::REG_THRESHOLD)
			cur_thr = stored[asdl_pkg::THR_W-1:0];
		else
			cur_ticks = stored[asdl_pkg::TICKS_W-1:0];
		cfg_writes++;
		// read back in the following transaction
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== stored)
			report_mismatch($sformatf("register %0d read %0h, wrote %0h", idx, rd, stored));
		@(posedge clk);
	endtask

	function automatic logic [15:0] random_accel;
		case ($urandom_range(9))
			0, 1, 2: return 16'($urandom);
			3, 4, 5, 6: return 16'(int'($urandom_range(1023)) - 512);
			default: return 16'($urandom_range(32767, 200));
		endcase
	endfunction

	task automatic random_run(int n, int tick_pct);
		detect_result_t none;
		none = '{1'b0, 1'b0, '0};
		repeat (n) begin
			if ($urandom_range(99) < tick_pct)
				send_item(asdl_pkg::OP_TICK, 16'($urandom), 1'b0, none);
			else
				send_item(asdl_pkg::OP_SAMPLE, random_accel(), 1'b0, none);
		end
	endtask

	// result check, receiver stalls and the watchdog
	always @(posedge clk) begin : result_check
		detect_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0h with nothing expected", m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.step)
					report_mismatch($sformatf("step %b, want %b", m_tdata[0], want.step));
				if (m_tdata[1] !== want.lock)
					report_mismatch($sformatf("lockout_active %b, want %b", m_tdata[1],
						want.lock));
				if (m_tdata[2 +: asdl_pkg::OUT_TOTAL_W] !== want.total)
					report_mismatch($sformatf("window_total %0h, want %0h",
						m_tdata[2 +: asdl_pkg::OUT_TOTAL_W], want.total));
				if (m_tdata[0] === 1'b1)
					steps_seen++;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned ph_thr   [6];
		int unsigned ph_ticks [6];
		int          ph_pct   [6];
		int          i;
		for (i = 0; i < asdl_pkg::WINDOW; i++)
			win_buf[i] = '0;
		win_pos   = 0;
		win_sum   = 0;
		hold_off  = 1'b0;
		hold_left = 0;
		cur_thr   = asdl_pkg::THR_RESET;
		cur_ticks = asdl_pkg::TICKS_RESET;

		// reset defaults first, then both threshold extremes and short lockouts
		stim_rows.push_back(typed_row(asdl_pkg::OP_TICK, 16'h0000, 1'b0, 1'b0, 0));
		stim_rows.push_back(typed_row(asdl_pkg::OP_SAMPLE, 16'h7FFF, 1'b1, 1'b1, 32767));
		stim_rows.push_back(item_row(asdl_pkg::OP_SAMPLE, 16'h7FFF, 1));
		stim_rows.push_back(item_row(asdl_pkg::OP_SAMPLE, 16'h8000, 1));
		stim_rows.push_back(item_row(asdl_pkg::OP_TICK, 16'hFFFF, 1));
		stim_rows.push_back(item_row(asdl_pkg::OP_TICK, 16'h0000, 498));
		stim_rows.push_back(item_row(asdl_pkg::OP_TICK, 16'h0000, 1));
		stim_rows.push_back(cfg_row(asdl_pkg::REG_THRESHOLD, 32'hFFFF_7FFF));
		stim_rows.push_back(item_row(asdl_pkg::OP_SAMPLE, 16'h7FFF, 1));
		stim_rows.push_back(cfg_row(asdl_pkg::REG_THRESHOLD, 32'h0000_0000));
		stim_rows.push_back(cfg_row(asdl_pkg::REG_LOCKOUT, 32'hABCD_0000));
		stim_rows.push_back(item_row(asdl_pkg::OP_SAMPLE, 16'h8000, 4));
		stim_rows.push_back(item_row(asdl_pkg::OP_SAMPLE, 16'h0000, 1));
		stim_rows.push_back(item_row(asdl_pkg::OP_SAMPLE, 16'h7FFF, 1));
		stim_rows.push_back(item_row(asdl_pkg::OP_SAMPLE, 16'h0001, 1));
		stim_rows.push_back(item_row(asdl_pkg::OP_TICK, 16'h5555, 1));
		stim_rows.push_back(item_row(asdl_pkg::OP_TICK, 16'hAAAA, 1));
		stim_rows.push_back(cfg_row(asdl_pkg::REG_LOCKOUT, 32'h0000_0002));
		stim_rows.push_back(cfg_row(asdl_pkg::REG_THRESHOLD, 32'h0000_009A));
		stim_rows.push_back(item_row(asdl_pkg::OP_SAMPLE, 16'h7FFF, 1));
		stim_rows.push_back(item_row(asdl_pkg::OP_TICK, 16'h0000, 2));
		stim_rows.push_back(item_row(asdl_pkg::OP_SAMPLE, 16'h0100, 1));

		ph_thr   = '{154, 0, 32767, $urandom_range(32767), 600, $urandom_range(2000)};
		ph_ticks = '{3, 0, 1, $urandom_range(20), 10, 65535};
		ph_pct   = '{35, 40, 30, 45, 40, 50};

		send_idle = 38;
		recv_idle = 52;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[r]) begin
			if (stim_rows[r].kind == ROW_CFG) begin
				drain();
				apb_write_reg(stim_rows[r].idx, stim_rows[r].value);
			end else begin
				repeat (stim_rows[r].reps)
					send_item(stim_rows[r].op, stim_rows[r].accel, stim_rows[r].typed,
						stim_rows[r].want);
			end
		end

		for (i = 0; i < 6; i++) begin
			if (i >= 4) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (i >= 2) begin
				send_idle = 52;
				recv_idle = 38;
			end
			drain();
			apb_write_reg(asdl_pkg::REG_THRESHOLD, ph_thr[i] | ($urandom << asdl_pkg::THR_W));
			apb_write_reg(asdl_pkg::REG_LOCKOUT, ph_ticks[i] | ($urandom << asdl_pkg::TICKS_W));
			random_run(30, ph_pct[i]);
		end

		drain();
		repeat (8) @(posedge clk);
		$display("run covered %0d input transactions (%0d ticks), %0d steps flagged",
			items_sent, ticks_sent, steps_seen);
		$display("%0d register writes over %0d random phases and three stall mixes",
			cfg_writes, 6);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
